[design/spci_pkg.sv]
// Shared types and constants for the speed PID core.
`default_nettype none
package spci_pkg;

    localparam int GAIN_W    = 32;
    localparam int LIMIT_W   = 15;
    localparam int DATA_W    = 16;
    localparam int ERR_W     = 17;
    localparam int DIFF_W    = 18;
    localparam int ACC_W     = 48;
    localparam int KMAG_W    = 47;
    localparam int MUL_A_W   = 33;
    localparam int MUL_B_W   = 18;
    localparam int PROD_W    = 51;
    localparam int DMAG_W    = 48;
    localparam int DIVD_W    = 66;
    localparam int DIVS_W    = 16;
    localparam int DIV_STEPS = 33;
    localparam int D_SAT_BITS = 60;
    localparam int PD_W      = 62;
    localparam int APB_AW    = 5;
    localparam int APB_DW    = 32;

    localparam logic REQ_CALC  = 1'b0;
    localparam logic REQ_CLEAR = 1'b1;

    localparam logic [2:0] REG_GAIN_P   = 3'd0;
    localparam logic [2:0] REG_GAIN_I   = 3'd1;
    localparam logic [2:0] REG_GAIN_D   = 3'd2;
    localparam logic [2:0] REG_OUT_LIM  = 3'd3;
    localparam logic [2:0] REG_INT_LIM  = 3'd4;

    localparam logic signed [GAIN_W-1:0] RST_GAIN_P  = 32'sd32768;
    localparam logic signed [GAIN_W-1:0] RST_GAIN_I  = 32'sd5243;
    localparam logic signed [GAIN_W-1:0] RST_GAIN_D  = 32'sd328;
    localparam logic [LIMIT_W-1:0]       RST_OUT_LIM = 15'd5000;
    localparam logic [LIMIT_W-1:0]       RST_INT_LIM = 15'd200;

    typedef struct packed {
        logic signed [GAIN_W-1:0] gain_p;
        logic signed [GAIN_W-1:0] gain_i;
        logic signed [GAIN_W-1:0] gain_d;
        logic [LIMIT_W-1:0]       output_limit;
        logic [LIMIT_W-1:0]       integral_limit;
    } cfg_t;

endpackage
`default_nettype wire

[design/spci_regs.sv]
// APB register file holding gains and limits.
`default_nettype none
module spci_regs (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [spci_pkg::APB_AW-1:0] paddr,
    input  wire logic [spci_pkg::APB_DW-1:0] pwdata,
    output logic [spci_pkg::APB_DW-1:0]      prdata,
    output logic                             pready,
    output spci_pkg::cfg_t                   cfg
);
    import spci_pkg::*;

    cfg_t       cfg_reg;
    logic [2:0] index;
    logic       wr_en;

    assign index  = paddr[APB_AW-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_p         <= RST_GAIN_P;
            cfg_reg.gain_i         <= RST_GAIN_I;
            cfg_reg.gain_d         <= RST_GAIN_D;
            cfg_reg.output_limit   <= RST_OUT_LIM;
            cfg_reg.integral_limit <= RST_INT_LIM;
        end
        else if (wr_en)
        begin
            case (index)
                REG_GAIN_P:  cfg_reg.gain_p         <= $signed(pwdata);
                REG_GAIN_I:  cfg_reg.gain_i         <= $signed(pwdata);
                REG_GAIN_D:  cfg_reg.gain_d         <= $signed(pwdata);
                REG_OUT_LIM: cfg_reg.output_limit   <= pwdata[LIMIT_W-1:0];
                REG_INT_LIM: cfg_reg.integral_limit <= pwdata[LIMIT_W-1:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        case (index)
            REG_GAIN_P:  prdata = cfg_reg.gain_p;
            REG_GAIN_I:  prdata = cfg_reg.gain_i;
            REG_GAIN_D:  prdata = cfg_reg.gain_d;
            REG_OUT_LIM: prdata = APB_DW'(cfg_reg.output_limit);
            REG_INT_LIM: prdata = APB_DW'(cfg_reg.integral_limit);
            default:     prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

[design/spci_mul.sv]
// Shared signed multiplier with registered product.
`default_nettype none
module spci_mul (
    input  wire logic                               clk,
    input  wire logic                               en,
    input  wire logic signed [spci_pkg::MUL_A_W-1:0] mul_a,
    input  wire logic signed [spci_pkg::MUL_B_W-1:0] mul_b,
    output logic signed [spci_pkg::PROD_W-1:0]       prod
);
    import spci_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;

    assign prod_next = PROD_W'(mul_a) * PROD_W'(mul_b);
    assign prod      = prod_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
        end
    end

endmodule
`default_nettype wire

[design/spci_div.sv]
// Restoring divider, two quotient bits per cycle.
`default_nettype none
module spci_div (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [spci_pkg::DIVD_W-1:0] dividend,
    input  wire logic [spci_pkg::DIVS_W-1:0] divisor,
    output logic [spci_pkg::DIVD_W-1:0]      quotient,
    output logic                             done
);
    import spci_pkg::*;

    localparam int CNT_W = $clog2(DIV_STEPS);

    // dq_reg shifts dividend bits out the top and quotient bits in the bottom
    logic [DIVD_W-1:0] dq_reg;
    logic [DIVS_W-1:0] rem_reg;
    logic [DIVS_W-1:0] divs_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [DIVS_W:0]   r1, r2;
    logic              ge1, ge2;
    logic [DIVS_W-1:0] rem1, rem_next;
    logic [DIVD_W-1:0] dq1, dq_next;

    always_comb
    begin
        r1       = {rem_reg, dq_reg[DIVD_W-1]};
        ge1      = r1 >= {1'b0, divs_reg};
        rem1     = ge1 ? DIVS_W'(r1 - {1'b0, divs_reg}) : r1[DIVS_W-1:0];
        dq1      = {dq_reg[DIVD_W-2:0], ge1};
        r2       = {rem1, dq1[DIVD_W-1]};
        ge2      = r2 >= {1'b0, divs_reg};
        rem_next = ge2 ? DIVS_W'(r2 - {1'b0, divs_reg}) : r2[DIVS_W-1:0];
        dq_next  = {dq1[DIVD_W-2:0], ge2};
    end

    assign quotient = dq_reg;
    assign done     = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dq_reg   <= dividend;
            rem_reg  <= '0;
            divs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            dq_reg  <= dq_next;
            rem_reg <= rem_next;
        end
    end

endmodule
`default_nettype wire

[design/speed_pid_conditional_integration_core.sv]
// Speed PID step with conditional-integration anti-windup.
// Request channel (req_valid/req_stall): req_type 0 runs one control step on
// target_value, measured_value and period_frac (Q0.16 s, 0 taken as 1);
// req_type 1 zeroes the integral and the previous error and gives no result.
// Result channel (rsp_valid/rsp_stall): drive_out, signed 16 bits.
// Gains and limits sit on the APB port at byte addresses 0,4,8,12,16.
// In a calculate step the shared 33x18 multiplier runs five products in
// sequence and the derivative divide runs at two quotient bits per cycle.
// req_stall is high from the cycle after the transfer until the result is
// loaded into the output register, so a new calculate step is taken only
// once the previous one has loaded its result; a clear completes in the
// transfer cycle itself.
// The result register holds drive_out while rsp_stall is high; the next step
// may run meanwhile but waits in its last cycle until the register is free.
// Reset loads the default gains and limits and zeroes the integral and the
// previous error; no clearing sweep is needed.
`default_nettype none
module speed_pid_conditional_integration_core #(
    parameter int GAIN_FRAC_BITS = 16
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [spci_pkg::APB_AW-1:0]         paddr,
    input  wire logic [spci_pkg::APB_DW-1:0]         pwdata,
    output logic [spci_pkg::APB_DW-1:0]              prdata,
    output logic                                     pready,
    input  wire logic                                req_valid,
    output logic                                     req_stall,
    input  wire logic                                req_type,
    input  wire logic signed [spci_pkg::DATA_W-1:0]  target_value,
    input  wire logic signed [spci_pkg::DATA_W-1:0]  measured_value,
    input  wire logic [spci_pkg::DATA_W-1:0]         period_frac,
    output logic                                     rsp_valid,
    input  wire logic                                rsp_stall,
    output logic signed [spci_pkg::DATA_W-1:0]       drive_out
);
    import spci_pkg::*;

    localparam int LIM_W = LIMIT_W + GAIN_FRAC_BITS;
    localparam int TOT_W = LIM_W + 1;

    typedef enum logic [3:0] {
        ST_IDLE, ST_MUL_P, ST_MUL_D, ST_DIV_LOAD, ST_DIV, ST_SUM_PD,
        ST_MUL_LO, ST_MUL_HI, ST_INTEG, ST_ACC, ST_TOTAL, ST_OUT
    } state_t;

    cfg_t cfg;

    state_t                     state_reg;
    logic signed [ERR_W-1:0]    err_reg;
    logic signed [ERR_W-1:0]    last_err_reg;
    logic signed [DIFF_W-1:0]   diff_reg;
    logic [DATA_W-1:0]          period_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [PD_W-1:0]     pd_reg;
    logic                       dneg_reg;
    logic [KMAG_W-1:0]          kmag_reg;
    logic                       kneg_reg;
    logic [DMAG_W-1:0]          im_lo_reg;
    logic [KMAG_W-1:0]          im_reg;
    logic                       inside_reg;
    logic signed [TOT_W-1:0]    tot_reg;
    logic signed [DATA_W-1:0]   out_reg;
    logic                       out_valid_reg;

    // shared multiplier
    logic                       mul_en;
    logic signed [MUL_A_W-1:0]  mul_a;
    logic signed [MUL_B_W-1:0]  mul_b;
    logic signed [PROD_W-1:0]   prod;
    logic [PROD_W-1:0]          prod_mag;

    // divider
    logic                       div_start;
    logic [DIVD_W-1:0]          div_dividend;
    logic [DIVD_W-1:0]          quotient;
    logic                       div_done;

    logic signed [ERR_W-1:0]    err_in;
    logic signed [DIFF_W-1:0]   diff_in;
    logic [PD_W-2:0]            dmag;
    logic signed [PD_W-1:0]     d_term;
    logic [LIM_W-1:0]           lim_out_w;
    logic [LIM_W-1:0]           lim_int_w;
    logic signed [PD_W-1:0]     lim_out_pd;
    logic [PD_W:0]              im_full;
    logic signed [ACC_W-1:0]    im_signed;
    logic signed [ACC_W:0]      acc_sum;
    logic signed [ACC_W:0]      lim_int_s;
    logic signed [ACC_W-1:0]    acc_next;
    logic signed [PD_W:0]       tot_sum;
    logic signed [PD_W:0]       lim_out_t;
    logic signed [TOT_W-1:0]    tot_next;
    logic [TOT_W-1:0]           tot_mag;
    logic [DATA_W-1:0]          drive_mag;
    logic signed [DATA_W-1:0]   drive_next;
    logic                       out_free;

    spci_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    spci_mul u_mul (
        .clk   (clk),
        .en    (mul_en),
        .mul_a (mul_a),
        .mul_b (mul_b),
        .prod  (prod)
    );

    spci_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (period_reg),
        .quotient (quotient),
        .done     (div_done)
    );

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = out_valid_reg;
    assign drive_out = out_reg;
    assign out_free  = !out_valid_reg || !rsp_stall;

    assign err_in  = ERR_W'(target_value) - ERR_W'(measured_value);
    assign diff_in = DIFF_W'(err_in) - DIFF_W'(last_err_reg);

    // multiplier operand select
    always_comb
    begin
        mul_en = 1'b1;
        mul_a  = '0;
        mul_b  = '0;
        case (state_reg)
            ST_MUL_P:
            begin
                mul_a = MUL_A_W'(cfg.gain_p);
                mul_b = MUL_B_W'(err_reg);
            end
            ST_MUL_D:
            begin
                mul_a = MUL_A_W'(cfg.gain_d);
                mul_b = diff_reg;
            end
            ST_DIV_LOAD:
            begin
                mul_a = MUL_A_W'(cfg.gain_i);
                mul_b = MUL_B_W'(err_reg);
            end
            ST_MUL_LO:
            begin
                mul_a = $signed({1'b0, kmag_reg[31:0]});
                mul_b = $signed({2'b00, period_reg});
            end
            ST_MUL_HI:
            begin
                mul_a = $signed(MUL_A_W'(kmag_reg[KMAG_W-1:32]));
                mul_b = $signed({2'b00, period_reg});
            end
            default: mul_en = 1'b0;
        endcase
    end

    assign prod_mag     = prod[PROD_W-1] ? PROD_W'(-prod) : PROD_W'(prod);
    assign div_start    = (state_reg == ST_DIV_LOAD);
    assign div_dividend = {2'b00, prod_mag[DMAG_W-1:0], 16'h0000};

    // derivative magnitude saturates at 2^60
    assign dmag   = (|quotient[DIVD_W-1:D_SAT_BITS]) ? (PD_W-1)'(1) << D_SAT_BITS
                                                     : quotient[PD_W-2:0];
    assign d_term = dneg_reg ? -$signed({1'b0, dmag}) : $signed({1'b0, dmag});

    assign lim_out_w  = {cfg.output_limit, {GAIN_FRAC_BITS{1'b0}}};
    assign lim_int_w  = {cfg.integral_limit, {GAIN_FRAC_BITS{1'b0}}};
    assign lim_out_pd = $signed(PD_W'(lim_out_w));

    // (m * dt) >> 16 from two partial products
    assign im_full = (PD_W+1)'(im_lo_reg) + ((PD_W+1)'(prod[30:0]) << 32);

    assign im_signed = kneg_reg ? -$signed({1'b0, im_reg}) : $signed({1'b0, im_reg});
    assign acc_sum   = (ACC_W+1)'(acc_reg) + (ACC_W+1)'(im_signed);
    assign lim_int_s = $signed((ACC_W+1)'(lim_int_w));

    always_comb
    begin
        if (acc_sum > lim_int_s)
            acc_next = ACC_W'(lim_int_s);
        else if (acc_sum < -lim_int_s)
            acc_next = ACC_W'(-lim_int_s);
        else
            acc_next = ACC_W'(acc_sum);
    end

    assign tot_sum   = (PD_W+1)'(pd_reg) + (PD_W+1)'(acc_reg);
    assign lim_out_t = $signed((PD_W+1)'(lim_out_w));

    always_comb
    begin
        if (tot_sum > lim_out_t)
            tot_next = TOT_W'(lim_out_t);
        else if (tot_sum < -lim_out_t)
            tot_next = TOT_W'(-lim_out_t);
        else
            tot_next = TOT_W'(tot_sum);
    end

    // truncate toward zero: shift the magnitude, then restore the sign
    assign tot_mag    = tot_reg[TOT_W-1] ? TOT_W'(-tot_reg) : TOT_W'(tot_reg);
    assign drive_mag  = {1'b0, tot_mag[LIM_W-1:GAIN_FRAC_BITS]};
    assign drive_next = tot_reg[TOT_W-1] ? -$signed(drive_mag) : $signed(drive_mag);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            acc_reg       <= '0;
            last_err_reg  <= '0;
        end
        else
        begin
            // a new result may load in the same cycle the old one transfers
            if (state_reg == ST_OUT && out_free)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !rsp_stall)
                out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (req_valid)
                    begin
                        if (req_type == REQ_CLEAR)
                        begin
                            acc_reg      <= '0;
                            last_err_reg <= '0;
                        end
                        else
                        begin
                            err_reg    <= err_in;
                            diff_reg   <= diff_in;
                            period_reg <= (period_frac == '0) ? DATA_W'(1) : period_frac;
                            state_reg  <= ST_MUL_P;
                        end
                    end
                end
                ST_MUL_P:    state_reg <= ST_MUL_D;
                ST_MUL_D:
                begin
                    pd_reg    <= PD_W'(prod);
                    state_reg <= ST_DIV_LOAD;
                end
                ST_DIV_LOAD:
                begin
                    dneg_reg  <= prod[PROD_W-1];
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    if (div_done)
                        state_reg <= ST_SUM_PD;
                end
                ST_SUM_PD:
                begin
                    pd_reg    <= pd_reg + d_term;
                    kmag_reg  <= prod_mag[KMAG_W-1:0];
                    kneg_reg  <= prod[PROD_W-1];
                    state_reg <= ST_MUL_LO;
                end
                ST_MUL_LO:   state_reg <= ST_MUL_HI;
                ST_MUL_HI:
                begin
                    im_lo_reg <= prod[DMAG_W-1:0];
                    state_reg <= ST_INTEG;
                end
                ST_INTEG:
                begin
                    im_reg     <= im_full[KMAG_W+15:16];
                    inside_reg <= (pd_reg < lim_out_pd) && (pd_reg > -lim_out_pd);
                    state_reg  <= ST_ACC;
                end
                ST_ACC:
                begin
                    if (inside_reg)
                        acc_reg <= acc_next;
                    state_reg <= ST_TOTAL;
                end
                ST_TOTAL:
                begin
                    tot_reg   <= tot_next;
                    state_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (out_free)
                    begin
                        out_reg       <= drive_next;
                        last_err_reg  <= err_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:     state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire
